// ----- hdl/lgt_pkg.sv -----
package lgt_pkg;

    // grid geometry
    localparam int GRID_ROWS = 24;
    localparam int GRID_COLS = 24;
    localparam int ROW_W     = $clog2(GRID_ROWS);

    // fixed field widths of the stream beats
    localparam int CELLS_W   = 24;
    localparam int INDEX_W   = 5;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 32;
    localparam int GEN_W     = 8;

    // register port
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam logic REG_IDX_GENERATIONS = 1'b0;
    localparam logic [GEN_W-1:0] GEN_RESET = 8'd1;

    typedef logic [GRID_COLS-1:0] row_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_EVOLVE,
        ST_EMIT
    } lgt_state_t;

    // per-cycle command to the row cells
    typedef struct packed {
        logic shift;   // every cell takes its lower neighbor's row
        logic evolve;  // every cell applies the life rule
        logic load;    // bottom cell takes the incoming beat, else wraps row zero
    } cell_ctl_t;

endpackage

// ----- hdl/lgt_cell.sv -----
module lgt_cell (
    input  logic              aclk,
    input  lgt_pkg::cell_ctl_t ctl,
    input  lgt_pkg::row_t     up_row,
    input  lgt_pkg::row_t     dn_row,
    input  lgt_pkg::row_t     shift_in,
    output lgt_pkg::row_t     row_q
);
    import lgt_pkg::*;

    row_t row_reg;
    row_t row_next;
    row_t life_row;

    // b3/s23 rule over the eight wrapped neighbors of each column
    always_comb begin
        int lf;
        int rt;
        logic [3:0] nbr;
        for (int c = 0; c < GRID_COLS; c++) begin
            lf = (c == 0) ? GRID_COLS - 1 : c - 1;
            rt = (c == GRID_COLS - 1) ? 0 : c + 1;
            nbr = 4'(up_row[lf]) + 4'(up_row[c]) + 4'(up_row[rt])
                + 4'(row_reg[lf]) + 4'(row_reg[rt])
                + 4'(dn_row[lf]) + 4'(dn_row[c]) + 4'(dn_row[rt]);
            life_row[c] = (nbr == 4'd3) || (row_reg[c] && (nbr == 4'd2));
        end
    end

    // shift, evolve or hold
    always_comb begin
        row_next = row_reg;
        if (ctl.shift) begin
            row_next = shift_in;
        end else if (ctl.evolve) begin
            row_next = life_row;
        end
    end

    always_ff @(posedge aclk) begin
        row_reg <= row_next;
    end

    assign row_q = row_reg;

endmodule

// ----- hdl/lgt_ctrl.sv -----
module lgt_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [lgt_pkg::GEN_W-1:0]     generations,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic                          m_tlast,
    output logic [lgt_pkg::ROW_W-1:0]     row_idx,
    output lgt_pkg::lgt_state_t           state,
    output lgt_pkg::cell_ctl_t            ctl
);
    import lgt_pkg::*;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GRID_ROWS - 1);

    lgt_state_t        state_reg, state_next;
    logic [ROW_W-1:0]  row_cnt_reg, row_cnt_next;
    logic [GEN_W-1:0]  gen_cnt_reg, gen_cnt_next;

    // state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            row_cnt_reg <= '0;
            gen_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            row_cnt_reg <= row_cnt_next;
            gen_cnt_reg <= gen_cnt_next;
        end
    end

    // load rows, run generations, then stream the grid out
    always_comb begin
        state_next   = state_reg;
        row_cnt_next = row_cnt_reg;
        gen_cnt_next = gen_cnt_reg;
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;
        ctl          = '0;
        unique case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                ctl.load = 1'b1;
                if (s_tvalid) begin
                    ctl.shift = 1'b1;
                    if (row_cnt_reg == LAST_ROW) begin
                        row_cnt_next = '0;
                        gen_cnt_next = generations;
                        state_next   = (generations == '0) ? ST_EMIT : ST_EVOLVE;
                    end else begin
                        row_cnt_next = row_cnt_reg + 1'b1;
                    end
                end
            end
            ST_EVOLVE: begin
                ctl.evolve   = 1'b1;
                gen_cnt_next = gen_cnt_reg - 1'b1;
                if (gen_cnt_reg == GEN_W'(1)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    ctl.shift = 1'b1;
                    if (row_cnt_reg == LAST_ROW) begin
                        row_cnt_next = '0;
                        state_next   = ST_LOAD;
                    end else begin
                        row_cnt_next = row_cnt_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next   = ST_LOAD;
                row_cnt_next = '0;
            end
        endcase
    end

    assign m_tlast = (row_cnt_reg == LAST_ROW);
    assign row_idx = row_cnt_reg;
    assign state   = state_reg;

endmodule

// ----- hdl/life_generation_torus.sv -----
// channel   | dir | beat fields (low bit up)                       | handshake
// s_        | in  | tdata: row_cells[23:0]                         | s_tvalid/s_tready
// m_        | out | tdata: out_row_cells[23:0], out_row_index[28:24]; tlast: last_row
//           |     |                                                | m_tvalid/m_tready
// apb       | in  | generations at byte address 0                  | psel/penable, pready=1
//
// one row beat per cycle while loading; the grid sits in a chain of 24 row cells
// after the last row, the chain runs the generations: all cells apply the rule at once
// then 24 output beats, one per cycle while m_tready is high
// reset clears the fsm, row count and sets generations to 1; grid contents are not reset
// m_tready low holds the chain and the output beat; no input is taken until the grid is out
module life_generation_torus (
    input  logic                            aclk,
    input  logic                            aresetn,
    // row_cells[23:0]
    input  logic [lgt_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // out_row_cells[23:0], out_row_index[28:24], zero[31:29]
    output logic [lgt_pkg::M_DATA_W-1:0]    m_tdata,
    output logic                            m_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lgt_pkg::APB_AW-1:0]      paddr,
    input  logic [lgt_pkg::APB_DW-1:0]      pwdata,
    output logic [lgt_pkg::APB_DW-1:0]      prdata,
    output logic                            pready
);
    import lgt_pkg::*;

    logic [GEN_W-1:0]  gen_reg;
    logic [ROW_W-1:0]  row_idx;
    lgt_state_t        state;
    cell_ctl_t         ctl;
    row_t              rows [GRID_ROWS];
    row_t              bottom_in;

    // register port
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_reg <= GEN_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == REG_IDX_GENERATIONS)) begin
            gen_reg <= pwdata[GEN_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_IDX_GENERATIONS) ? APB_DW'(gen_reg) : '0;

    // sequencer
    lgt_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .generations (gen_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tlast     (m_tlast),
        .row_idx     (row_idx),
        .state       (state),
        .ctl         (ctl)
    );

    // bottom cell takes the new row while loading, else row zero wraps around
    assign bottom_in = ctl.load ? GRID_COLS'(s_tdata[CELLS_W-1:0]) : rows[0];

    // chain of row cells, top row in cell zero
    for (genvar i = 0; i < GRID_ROWS; i++) begin : g_row
        localparam int UP = (i == 0) ? GRID_ROWS - 1 : i - 1;
        localparam int DN = (i == GRID_ROWS - 1) ? 0 : i + 1;
        lgt_cell u_cell (
            .aclk     (aclk),
            .ctl      (ctl),
            .up_row   (rows[UP]),
            .dn_row   (rows[DN]),
            .shift_in ((i == GRID_ROWS - 1) ? bottom_in : rows[DN]),
            .row_q    (rows[i])
        );
    end

    // output beat straight from the head of the chain
    assign m_tdata = {{(M_DATA_W - CELLS_W - INDEX_W){1'b0}},
                      INDEX_W'(row_idx), CELLS_W'(rows[0])};

    // input and output never open together
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output open at once");

    // last output beat returns to loading at row zero
    a_back_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && row_idx == '0))
        else $error("no return to loading after last row");

    // a completed grid with nonzero generations starts evolving
    a_evolve_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && m_tlast && gen_reg != '0) |=> (state == ST_EVOLVE))
        else $error("generation phase skipped");

    // output phase starts at the top row
    a_emit_top: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> (row_idx == '0))
        else $error("output does not start at row zero");

endmodule

// ----- tb/tb_life_generation_torus.sv -----
module tb_life_generation_torus;
    timeunit 1ns;
    timeprecision 1ps;

    import lgt_pkg::*;

    localparam int NUM_GRIDS    = 6;
    localparam int HOLD_AT_BEAT = 77;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 8;
    localparam int END_CYCLES   = 64;
    localparam int LIMIT_CYCLES = 200000;
    localparam logic [APB_AW-1:0] ADDR_GENERATIONS = {REG_IDX_GENERATIONS, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_SPARE       = 3'd4;

    // row patterns for the fixed first grid: solid, empty, wrap blinkers, stripes, glider
    localparam row_t DIRECTED_ROWS [GRID_ROWS] = '{
        24'hFFFFFF, 24'h000000, 24'h000001, 24'h000001, 24'h000001, 24'h800000,
        24'h800000, 24'h000000, 24'h0E0000, 24'h000000, 24'h001800, 24'h002400,
        24'h001800, 24'h000000, 24'h555555, 24'hAAAAAA, 24'h000000, 24'h000000,
        24'h000000, 24'h000000, 24'h000000, 24'h800002, 24'h000001, 24'h800001
    };

    typedef enum {FILL_UNIFORM, FILL_SPARSE, FILL_DENSE, FILL_SOLID, FILL_SHAPES} fill_t;

    typedef struct {
        row_t               cells;
        logic [INDEX_W-1:0] index;
        logic               last;
    } out_beat_t;

    // grid predictor and queue of rows still to be emitted
    class life_scoreboard;
        row_t             grid [GRID_ROWS];
        int unsigned      rows_in;
        logic [GEN_W-1:0] gen_count;
        out_beat_t        expected_rows [$];
        int unsigned      errors;

        function new();
            rows_in   = 0;
            gen_count = GEN_RESET;
            errors    = 0;
            foreach (grid[r]) grid[r] = '0;
        endfunction

        function void write_reg(int unsigned reg_idx, logic [APB_DW-1:0] value);
            if (reg_idx == REG_IDX_GENERATIONS) gen_count = value[GEN_W-1:0];
        endfunction

        function int pending();
            return expected_rows.size();
        endfunction

        // one b3/s23 step, all cells at once, edges wrapping
        function void next_generation();
            row_t nxt [GRID_ROWS];
            int   n;
            for (int r = 0; r < GRID_ROWS; r++) begin
                nxt[r] = '0;
                for (int c = 0; c < GRID_COLS; c++) begin
                    n = 0;
                    for (int dr = -1; dr <= 1; dr++) begin
                        for (int dc = -1; dc <= 1; dc++) begin
                            if (dr != 0 || dc != 0)
                                n += grid[(r + dr + GRID_ROWS) % GRID_ROWS]
                                         [(c + dc + GRID_COLS) % GRID_COLS];
                        end
                    end
                    nxt[r][c] = (n == 3) || (grid[r][c] && n == 2);
                end
            end
            grid = nxt;
        endfunction

        function void note_row(row_t row);
            out_beat_t beat;
            if (rows_in >= GRID_ROWS) rows_in = 0;
            grid[rows_in] = row;
            rows_in++;
            if (rows_in == GRID_ROWS) begin
                repeat (gen_count) next_generation();
                for (int r = 0; r < GRID_ROWS; r++) begin
                    beat.cells = grid[r];
                    beat.index = INDEX_W'(r);
                    beat.last  = (r == GRID_ROWS - 1);
                    expected_rows.push_back(beat);
                end
                rows_in = 0;
            end
        endfunction

        function void check_beat(logic [M_DATA_W-1:0] data, logic last);
            out_beat_t want;
            if (expected_rows.size() == 0) begin
                $error("output beat with no row expected: tdata %h tlast %b", data, last);
                errors++;
                return;
            end
            want = expected_rows.pop_front();
            if (data[CELLS_W-1:0] !== want.cells) begin
                $error("out_row_cells expected %h got %h", want.cells, data[CELLS_W-1:0]);
                errors++;
            end
            if (data[CELLS_W+INDEX_W-1:CELLS_W] !== want.index) begin
                $error("out_row_index expected %0d got %0d", want.index,
                       data[CELLS_W+INDEX_W-1:CELLS_W]);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_row expected %b got %b", want.last, last);
                errors++;
            end
            if (data[M_DATA_W-1:CELLS_W+INDEX_W] !== '0) begin
                $error("tdata pad expected 0 got %h", data[M_DATA_W-1:CELLS_W+INDEX_W]);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    // row_cells[23:0]
    logic [S_DATA_W-1:0]  s_tdata  = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // out_row_cells[23:0], out_row_index[28:24], zero[31:29]
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tlast;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [APB_AW-1:0]    paddr    = '0;
    logic [APB_DW-1:0]    pwdata   = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    life_scoreboard sb = new();
    bit             send_steady = 1'b0;
    int unsigned    beats_seen  = 0;
    int unsigned    cycles      = 0;

    life_generation_torus dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        while (cycles < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycles++;
        end
        $display("[life_generation_torus] ERROR");
        $finish;
    end

    function automatic row_t random_row(fill_t fill);
        row_t row;
        case (fill)
            FILL_SPARSE: row = row_t'($urandom & $urandom & $urandom);
            FILL_DENSE:  row = row_t'($urandom | $urandom);
            FILL_SOLID:  row = $urandom_range(1) ? '1 : '0;
            FILL_SHAPES: row = (24'h7 << $urandom_range(GRID_COLS - 1))
                             | (24'h1 << $urandom_range(GRID_COLS - 1));
            default:     row = row_t'($urandom);
        endcase
        return row;
    endfunction

    // one row beat, at times with a random gap ahead of it unless send_steady is set
    task automatic send_row(row_t row);
        if (!send_steady && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row;
        do @(posedge aclk); while (!s_tready);
        sb.note_row(row);
        @(negedge aclk);
    endtask

    task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(addr >> 2, data);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic apb_read(logic [APB_AW-1:0] addr, output logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        data = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    // wait for every expected row, then let the block settle
    task automatic drain(int settle);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
        @(negedge aclk);
    endtask

    // result side: random stalls, one long hold, one stall-free stretch
    initial begin
        int unsigned hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                sb.check_beat(m_tdata, m_tlast);
                beats_seen++;
            end
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && beats_seen == HOLD_AT_BEAT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else if (beats_seen >= 120 && beats_seen < 168) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 35);
            end
        end
    end

    // stimulus
    initial begin
        logic [GEN_W-1:0]  gens;
        logic [APB_DW-1:0] rd;
        fill_t             fill;
        int unsigned       fails;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // fixed grid under the reset generation count
        for (int r = 0; r < GRID_ROWS; r++) send_row(DIRECTED_ROWS[r]);
        s_tvalid <= 1'b0;

        // random grids; grids 3 and 5 follow without a pause
        for (int g = 0; g < NUM_GRIDS; g++) begin
            if (g != 3 && g != 5) begin
                drain(DRAIN_CYCLES);
                case (g)
                    0:       gens = '0;
                    1:       gens = '1;
                    2:       gens = 8'd2;
                    4:       gens = GEN_W'($urandom_range(254, 3));
                    default: gens = 8'd1;
                endcase
                apb_write(ADDR_GENERATIONS, {24'($urandom), gens});
                if (g == 4) apb_write(ADDR_SPARE, $urandom);
                apb_read(ADDR_GENERATIONS, rd);
                if (rd[GEN_W-1:0] !== sb.gen_count) begin
                    $error("generations readback expected %0d got %0d",
                           sb.gen_count, rd[GEN_W-1:0]);
                    sb.errors++;
                end
            end
            send_steady = (g == 1);
            fill = fill_t'($urandom_range(FILL_SHAPES));
            for (int r = 0; r < GRID_ROWS; r++)
                send_row(($urandom_range(99) < 20) ? row_t'($urandom) : random_row(fill));
            if (g != 2 && g != 4) s_tvalid <= 1'b0;
        end
        send_steady = 1'b0;

        drain(END_CYCLES);
        fails = sb.errors + sb.pending();
        if (fails == 0)
            $display("[life_generation_torus] OK");
        else
            $display("[life_generation_torus] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/lgt_pkg.sv
hdl/lgt_cell.sv
hdl/lgt_ctrl.sv
hdl/life_generation_torus.sv
tb/tb_life_generation_torus.sv
